// ===== src/anag_pkg.sv =====
// Shared types and constants for the anagram checker.
package anag_pkg;

   // Symbol alphabet: one table entry per byte value
   localparam int SYMBOLS = 256;
   localparam int SYM_W   = 8;

   typedef logic [SYM_W-1:0] anag_sym_type;

   // One request: a byte of one of the two strings
   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             from_second;
      logic             last;
   } anag_req_type;

   // One result per string pair
   typedef struct packed {
      logic is_anagram;
      logic overflow;
   } anag_rsp_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_SWEEP,
      ST_FINISH
   } anag_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;   // take the request, count its length, read its entry
      logic update;   // write back the adjusted entry
      logic sweep;    // read and zero the entry at the sweep index
      logic finish;   // load the result register and clear the lengths
   } anag_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic last;        // held request was the final byte of the pair
      logic sweep_done;  // sweep index sits on the final entry
      logic rsp_free;    // result register can take a new result
   } anag_sts_type;

endpackage

// ===== src/anag_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module anag_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old data on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/anag_ctrl.sv =====
// Controller state machine for the anagram checker.
module anag_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  anag_pkg::anag_sts_type sts,
   output logic                  req_stall,
   output anag_pkg::anag_cmd_type cmd
);
   import anag_pkg::*;

   anag_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.sweep_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = sts.last ? ST_SWEEP : ST_IDLE;
         end
         ST_SWEEP: begin
            if (sts.sweep_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
         end
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = sts.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== src/anag_dp.sv =====
// Datapath: difference table, length counters, sweep check and result register.
module anag_dp #(
   parameter int MAX_LEN = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  anag_pkg::anag_cmd_type cmd,
   input  anag_pkg::anag_req_type req_data,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output anag_pkg::anag_rsp_type rsp_data,
   output anag_pkg::anag_sts_type sts
);
   import anag_pkg::*;

   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int DIFF_W = LEN_W + 1;

   // Held request
   anag_sym_type sym_ff, sym_in;
   logic         second_ff, second_in;
   logic         last_ff, last_in;
   logic         counted_ff, counted_in;

   // Pair state
   logic [LEN_W-1:0] len1_ff, len1_in;
   logic [LEN_W-1:0] len2_ff, len2_in;
   logic             ovf_ff, ovf_in;

   // Sweep state
   anag_sym_type idx_ff, idx_in;
   logic         chk_ff, chk_in;
   logic         ok_ff, ok_in;
   logic         ok_now;

   // Result register
   logic         rsp_valid_ff, rsp_valid_in;
   anag_rsp_type rsp_ff, rsp_in;

   // Table port
   logic              wr_en;
   anag_sym_type      wr_addr;
   logic [DIFF_W-1:0] wr_data;
   anag_sym_type      rd_addr;
   logic [DIFF_W-1:0] rd_data;
   logic              len_full;

   anag_ram #(
      .WIDTH(DIFF_W),
      .DEPTH(SYMBOLS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Table addressing: sweep index on sweep, request symbol otherwise
   always_comb begin
      rd_addr = cmd.sweep ? idx_ff : req_data.symbol;
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = '0;
      if (cmd.update) begin
         wr_en   = counted_ff;
         wr_addr = sym_ff;
         wr_data = second_ff ? rd_data - DIFF_W'(1) : rd_data + DIFF_W'(1);
      end else if (cmd.sweep) begin
         wr_en = 1'b1;
      end
   end

   // Request capture and length counting
   always_comb begin
      sym_in     = sym_ff;
      second_in  = second_ff;
      last_in    = last_ff;
      counted_in = counted_ff;
      len1_in    = len1_ff;
      len2_in    = len2_ff;
      ovf_in     = ovf_ff;
      len_full   = (req_data.from_second ? len2_ff : len1_ff) >= LEN_W'(MAX_LEN);
      if (cmd.accept) begin
         sym_in     = req_data.symbol;
         second_in  = req_data.from_second;
         last_in    = req_data.last;
         counted_in = !len_full;
         if (len_full) begin
            ovf_in = 1'b1;
         end else if (req_data.from_second) begin
            len2_in = len2_ff + LEN_W'(1);
         end else begin
            len1_in = len1_ff + LEN_W'(1);
         end
      end else if (cmd.finish) begin
         len1_in = '0;
         len2_in = '0;
         ovf_in  = 1'b0;
      end
   end

   // Sweep: read data checked in the cycle after its address was issued
   always_comb begin
      idx_in = cmd.sweep ? idx_ff + SYM_W'(1) : idx_ff;
      chk_in = cmd.sweep;
      ok_now = ok_ff & ~(chk_ff & (rd_data != '0));
      if (cmd.update && last_ff) begin
         ok_in = !ovf_ff && (len1_ff == len2_ff);
      end else begin
         ok_in = ok_now;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      if (cmd.finish) begin
         rsp_valid_in      = 1'b1;
         rsp_in.is_anagram = ok_now;
         rsp_in.overflow   = ovf_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len1_ff      <= '0;
         len2_ff      <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len1_ff      <= len1_in;
         len2_ff      <= len2_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sym_ff     <= sym_in;
      second_ff  <= second_in;
      last_ff    <= last_in;
      counted_ff <= counted_in;
      ok_ff      <= ok_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_ff;
   assign sts.last       = last_ff;
   assign sts.sweep_done = (idx_ff == SYM_W'(SYMBOLS - 1));
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;

endmodule

// ===== src/anagram_check.sv =====
// Top level of the anagram checker: byte histogram differences per string pair.
//
//   channel  | ports                          | moves
//   ---------+--------------------------------+-----------------------------------
//   request  | req_valid, req_stall, req_data | one byte, string tag, last flag
//   result   | rsp_valid, rsp_stall, rsp_data | is_anagram and overflow per pair
//
// Each request is a read of its table entry, then the write-back; req_stall
// stays high during the write-back. A request marked last adds a sweep of all
// 256 table entries (check and zero), then a load of the result register.
// After reset the table is zeroed by a sweep of all 256 entries; req_stall stays high.
// The result register holds a result under rsp_stall while the next pair's
// requests are taken; a further result waits until the register is free.
module anagram_check #(
   parameter int MAX_LEN = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  anag_pkg::anag_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output anag_pkg::anag_rsp_type rsp_data
);
   import anag_pkg::*;

   anag_cmd_type cmd;
   anag_sts_type sts;

   anag_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .sts      (sts),
      .req_stall(req_stall),
      .cmd      (cmd)
   );

   anag_dp #(
      .MAX_LEN(MAX_LEN)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .sts      (sts)
   );

endmodule
